// ===== rtl/nqb_pkg.sv =====
// shared types for the n-queens backtracking search block
package nqb_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    typedef enum logic {
        KIND_MARK  = 1'b0,
        KIND_SOLVE = 1'b1
    } kind_t;

endpackage

// ===== rtl/n_queens_backtrack_with_fixed_queens.sv =====
// n-queens backtracking search with preplaced queens
//
// Request channel (req_valid / req_stall): a request of kind mark places a
// fixed queen at (queen_row, queen_col). Marks off the board are dropped.
// A request of kind solve starts a depth-first search with rows filled in
// order and columns tried in ascending order. req_stall is high from the
// solve until its last result has been taken. The search is a single
// sequencer around one candidate unit: each cycle it either places a
// queen in the current row, using the lowest free column from a mask and
// priority encoder, or backtracks one row, or, with no free column in the
// first row, ends the search. It goes on until the last row is filled or
// the first row runs dry, and then presents the first result.
// Result channel (res_valid / res_stall): BOARD_SIZE results, one per row,
// with found set, or one result with found clear; last marks the final one.
// One result leaves per cycle while res_stall is low; a stalled result
// holds steady and the block waits. The marks are cleared when the search
// ends and the occupancy masks after the last result. Reset clears the
// marks and masks and returns the block to idle.
module n_queens_backtrack_with_fixed_queens #(
    parameter int BOARD_SIZE = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic       kind,
    input  logic [2:0] queen_row,
    input  logic [2:0] queen_col,
    output logic       res_valid,
    input  logic       res_stall,
    output logic       found,
    output logic [2:0] board_row,
    output logic [2:0] queen_column,
    output logic       last
);

    localparam int N   = BOARD_SIZE;
    localparam int RW  = $clog2(N);
    localparam int DW  = 2 * N - 1;
    localparam int DBW = $clog2(DW);

    nqb_pkg::state_t state_reg, state_next;

    logic [RW-1:0] row_reg, row_next;
    logic [RW:0]   start_reg, start_next;
    logic [N-1:0]  cols_reg, cols_next;
    logic [DW-1:0] rise_reg, rise_next;
    logic [DW-1:0] fall_reg, fall_next;
    logic          found_reg, found_next;
    logic [RW-1:0] out_row_reg, out_row_next;
    logic [N-1:0]  marks_reg [N];
    logic [N-1:0]  marks_next [N];
    logic [RW-1:0] chosen_reg [N];

    logic          req_acc, res_acc, res_last;
    logic [N-1:0]  row_marks, allowed, blocked, ge_start, cand;
    logic [DW-1:0] rise_win, fall_win;
    logic [RW-1:0] pick;
    logic          hit;
    logic [RW-1:0] rd_addr, chosen_rd;
    logic [RW-1:0] tog_row, tog_col;
    logic          tog_en, chosen_we;
    logic [DBW-1:0] rise_idx, fall_idx;

    assign req_acc  = req_valid && !req_stall;
    assign res_acc  = res_valid && !res_stall;
    assign res_last = !found_reg || (out_row_reg == RW'(N - 1));

    // candidate unit: free squares in the current row at or above start
    always_comb
    begin
        row_marks = marks_reg[row_reg];
        if (row_marks == '0)
            allowed = '1;
        else if ((row_marks & (row_marks - N'(1))) == '0)
            allowed = row_marks;
        else
            allowed = '0;
        rise_win = rise_reg >> row_reg;
        fall_win = fall_reg >> row_reg;
        for (int c = 0; c < N; c++)
        begin
            blocked[c] = cols_reg[c] | rise_win[c] | fall_win[N - 1 - c];
        end
        ge_start = {N{1'b1}} << start_reg;
        cand     = allowed & ~blocked & ge_start;
        hit      = |cand;
        pick     = '0;
        for (int c = N - 1; c >= 0; c--)
        begin
            if (cand[c])
                pick = RW'(c);
        end
    end

    assign rd_addr   = (state_reg == nqb_pkg::ST_SEARCH) ? row_reg - RW'(1) : out_row_reg;
    assign chosen_rd = chosen_reg[rd_addr];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nqb_pkg::ST_IDLE:
            begin
                if (req_acc && kind == nqb_pkg::KIND_SOLVE)
                    state_next = nqb_pkg::ST_SEARCH;
            end
            nqb_pkg::ST_SEARCH:
            begin
                if (hit && row_reg == RW'(N - 1))
                    state_next = nqb_pkg::ST_EMIT;
                else if (!hit && row_reg == '0)
                    state_next = nqb_pkg::ST_EMIT;
            end
            nqb_pkg::ST_EMIT:
            begin
                if (res_acc && res_last)
                    state_next = nqb_pkg::ST_IDLE;
            end
            default:
                state_next = nqb_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req_stall    = (state_reg != nqb_pkg::ST_IDLE);
        res_valid    = (state_reg == nqb_pkg::ST_EMIT);
        found        = found_reg;
        last         = res_last;
        board_row    = found_reg ? 3'(out_row_reg) : 3'd0;
        queen_column = found_reg ? 3'(chosen_rd) : 3'd0;
    end

    // datapath next values
    always_comb
    begin
        row_next     = row_reg;
        start_next   = start_reg;
        found_next   = found_reg;
        out_row_next = out_row_reg;
        marks_next   = marks_reg;
        tog_en       = 1'b0;
        tog_row      = row_reg;
        tog_col      = pick;
        chosen_we    = 1'b0;
        case (state_reg)
            nqb_pkg::ST_IDLE:
            begin
                row_next   = '0;
                start_next = '0;
                if (req_acc && kind == nqb_pkg::KIND_MARK &&
                    32'(queen_row) < N && 32'(queen_col) < N)
                    marks_next[RW'(queen_row)] = marks_reg[RW'(queen_row)] |
                                                  (N'(1) << queen_col);
            end
            nqb_pkg::ST_SEARCH:
            begin
                tog_en = 1'b1;
                if (hit)
                begin
                    chosen_we = 1'b1;
                    if (row_reg == RW'(N - 1))
                    begin
                        found_next   = 1'b1;
                        out_row_next = '0;
                        for (int r = 0; r < N; r++)
                            marks_next[r] = '0;
                    end
                    else
                    begin
                        row_next   = row_reg + RW'(1);
                        start_next = '0;
                    end
                end
                else if (row_reg == '0)
                begin
                    tog_en       = 1'b0;
                    found_next   = 1'b0;
                    out_row_next = '0;
                    for (int r = 0; r < N; r++)
                        marks_next[r] = '0;
                end
                else
                begin
                    // backtrack: lift the queen of the previous row
                    tog_row    = row_reg - RW'(1);
                    tog_col    = chosen_rd;
                    row_next   = row_reg - RW'(1);
                    start_next = {1'b0, chosen_rd} + (RW + 1)'(1);
                end
            end
            nqb_pkg::ST_EMIT:
            begin
                if (res_acc && !res_last)
                    out_row_next = out_row_reg + RW'(1);
            end
            default:
            begin
            end
        endcase

        rise_idx  = DBW'(tog_row) + DBW'(tog_col);
        fall_idx  = DBW'(tog_row) + DBW'(N - 1) - DBW'(tog_col);
        cols_next = cols_reg;
        rise_next = rise_reg;
        fall_next = fall_reg;
        if (tog_en)
        begin
            cols_next = cols_reg ^ (N'(1) << tog_col);
            rise_next = rise_reg ^ (DW'(1) << rise_idx);
            fall_next = fall_reg ^ (DW'(1) << fall_idx);
        end
        if (state_reg == nqb_pkg::ST_EMIT && res_acc && res_last)
        begin
            cols_next = '0;
            rise_next = '0;
            fall_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= nqb_pkg::ST_IDLE;
            row_reg     <= '0;
            start_reg   <= '0;
            cols_reg    <= '0;
            rise_reg    <= '0;
            fall_reg    <= '0;
            found_reg   <= 1'b0;
            out_row_reg <= '0;
            for (int r = 0; r < N; r++)
                marks_reg[r] <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            start_reg   <= start_next;
            cols_reg    <= cols_next;
            rise_reg    <= rise_next;
            fall_reg    <= fall_next;
            found_reg   <= found_next;
            out_row_reg <= out_row_next;
            marks_reg   <= marks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chosen_we)
            chosen_reg[row_reg] <= pick;
    end

endmodule

// ===== rtl/nqb_checker.sv =====
// port-level checks for the n-queens search block, bound into the search block module
module nqb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_stall,
    input logic       res_valid,
    input logic       res_stall,
    input logic       found,
    input logic [2:0] board_row,
    input logic [2:0] queen_column,
    input logic       last
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(found) &&
        $stable(board_row) && $stable(queen_column) && $stable(last))
        else $error("stalled result changed");

    // no new request is taken while results are going out
    a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> req_stall)
        else $error("request channel open during result phase");

    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !found |-> last && board_row == 3'd0 && queen_column == 3'd0)
        else $error("malformed not-found result");

    // rows of a solution come out in order with no gap
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && found && !last |=>
        res_valid && found && board_row == 3'($past(board_row) + 3'd1))
        else $error("solution rows out of order");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && last |=> !res_valid)
        else $error("result after last");

endmodule

bind n_queens_backtrack_with_fixed_queens nqb_checker u_nqb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .found        (found),
    .board_row    (board_row),
    .queen_column (queen_column),
    .last         (last)
);

// ===== tb/queens_checker.sv =====
// request/result monitor with a backtracking predictor for the n-queens search block
module queens_checker
    import nqb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_stall,
    input  logic       kind,
    input  logic [2:0] queen_row,
    input  logic [2:0] queen_col,
    input  logic       res_valid,
    input  logic       res_stall,
    input  logic       found,
    input  logic [2:0] board_row,
    input  logic [2:0] queen_column,
    input  logic       last,
    output int         fail_count,
    output int         results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BOARD = 8;

    typedef struct packed {
        logic       found;
        logic [2:0] row;
        logic [2:0] column;
        logic       last;
    } row_answer_t;

    row_answer_t        answers_due[$];
    row_answer_t        want;
    logic [7:0][7:0]    fixed_marks;
    logic [7:0][2:0]    placement;
    logic               solvable;

    // depth-first search, rows in order, columns ascending; marks pin a row to one column
    function automatic logic place_queens(input logic [7:0][7:0] marks,
                                          output logic [7:0][2:0] picks);
        int         depth;
        int         col;
        logic [7:0] col_busy;
        logic [14:0] up_busy;
        logic [14:0] down_busy;
        logic       done;
        logic       hit;
        depth = 0;
        col = 0;
        col_busy = '0;
        up_busy = '0;
        down_busy = '0;
        done = 1'b0;
        hit = 1'b0;
        picks = '0;
        while (!done)
        begin
            while (col < BOARD && ((marks[depth] & ~(8'd1 << col)) != 8'd0 || col_busy[col]
                   || up_busy[depth + col] || down_busy[depth + BOARD - 1 - col]))
                col++;
            if (col < BOARD)
            begin
                picks[depth] = 3'(col);
                col_busy[col] = 1'b1;
                up_busy[depth + col] = 1'b1;
                down_busy[depth + BOARD - 1 - col] = 1'b1;
                depth++;
                col = 0;
                if (depth == BOARD)
                begin
                    hit = 1'b1;
                    done = 1'b1;
                end
            end
            else if (depth == 0)
                done = 1'b1;
            else
            begin
                // backtrack one row and resume past the column it held
                depth--;
                col = picks[depth];
                col_busy[col] = 1'b0;
                up_busy[depth + col] = 1'b0;
                down_busy[depth + BOARD - 1 - col] = 1'b0;
                col++;
            end
        end
        return hit;
    endfunction

    initial
    begin
        fixed_marks = '0;
        fail_count = 0;
        results_owed = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("unexpected result: found %0d row %0d column %0d last %0d",
                           found, board_row, queen_column, last);
                    fail_count++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, found);
                        fail_count++;
                    end
                    if (board_row !== want.row)
                    begin
                        $error("board_row: expected %0d, got %0d", want.row, board_row);
                        fail_count++;
                    end
                    if (queen_column !== want.column)
                    begin
                        $error("queen_column: expected %0d, got %0d", want.column, queen_column);
                        fail_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        fail_count++;
                    end
                end
            end

            if (req_valid && !req_stall)
            begin
                if (kind == KIND_MARK)
                begin
                    if (queen_row < BOARD && queen_col < BOARD)
                        fixed_marks[queen_row][queen_col] = 1'b1;
                end
                else
                begin
                    solvable = place_queens(fixed_marks, placement);
                    if (solvable)
                    begin
                        for (int r = 0; r < BOARD; r++)
                            answers_due.push_back({1'b1, 3'(r), placement[r], r == BOARD - 1});
                    end
                    else
                        answers_due.push_back({1'b0, 3'd0, 3'd0, 1'b1});
                    fixed_marks = '0;
                end
            end
            results_owed = answers_due.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// stimulus and verdict for the n-queens backtracking search block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nqb_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int BOARD        = 8;
    localparam int ITEM_TARGET  = 290;
    localparam int QUIET_LIMIT  = 20000;
    localparam int SQUEEZE_LEN  = 2500;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [2:0] SOL_TABLE [0:2][0:7] = '{
        '{3'd0, 3'd4, 3'd7, 3'd5, 3'd2, 3'd6, 3'd1, 3'd3},
        '{3'd0, 3'd5, 3'd7, 3'd2, 3'd6, 3'd3, 3'd1, 3'd4},
        '{3'd1, 3'd3, 3'd5, 3'd7, 3'd2, 3'd0, 3'd6, 3'd4}
    };

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    logic       kind;
    logic [2:0] queen_row;
    logic [2:0] queen_col;
    logic       res_valid;
    logic       res_stall;
    logic       found;
    logic [2:0] board_row;
    logic [2:0] queen_column;
    logic       last;

    int   mismatches;
    int   results_owed;
    int   requests_sent;
    int   quiet_cycles;
    int   hold_left;
    logic no_gaps;
    logic squeeze_req;
    logic squeeze_done;

    n_queens_backtrack_with_fixed_queens DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .queen_row    (queen_row),
        .queen_col    (queen_col),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .found        (found),
        .board_row    (board_row),
        .queen_column (queen_column),
        .last         (last)
    );

    queens_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .queen_row    (queen_row),
        .queen_col    (queen_col),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .found        (found),
        .board_row    (board_row),
        .queen_column (queen_column),
        .last         (last),
        .fail_count   (mismatches),
        .results_owed (results_owed)
    );

    initial
        clk = 1'b0;

    always #(HALF_PERIOD) clk = ~clk;

    task automatic send_request(input kind_t k, input logic [2:0] r, input logic [2:0] c);
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < 32)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        kind      <= k;
        queen_row <= r;
        queen_col <= c;
        do
            @(posedge clk);
        while (req_stall);
        requests_sent++;
    endtask

    task automatic mark_request(input logic [2:0] r, input logic [2:0] c);
        send_request(KIND_MARK, r, c);
    endtask

    // solve ignores the coordinates, so they carry random bits
    task automatic solve_request();
        send_request(KIND_SOLVE, 3'($urandom_range(7)), 3'($urandom_range(7)));
    endtask

    // one of the known solutions under a random board symmetry
    task automatic pick_placement(output logic [7:0][2:0] cols);
        logic [7:0][2:0] base;
        logic [7:0][2:0] turned;
        int              pick;
        logic            swap;
        logic            flip_r;
        logic            flip_c;
        pick = $urandom_range(2);
        swap = 1'($urandom_range(1));
        flip_r = 1'($urandom_range(1));
        flip_c = 1'($urandom_range(1));
        for (int r = 0; r < BOARD; r++)
            base[r] = SOL_TABLE[pick][r];
        for (int r = 0; r < BOARD; r++)
        begin
            if (swap)
                turned[base[r]] = 3'(r);
            else
                turned[r] = base[r];
        end
        for (int r = 0; r < BOARD; r++)
            cols[flip_r ? BOARD - 1 - r : r] = flip_c ? 3'(BOARD - 1) - turned[r] : turned[r];
    endtask

    // receiver: random stalls, plus one long hold-off once requested
    initial
    begin
        res_stall = 1'b0;
        hold_left = 0;
        squeeze_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else if (squeeze_req && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                hold_left = SQUEEZE_LEN - 1;
                res_stall <= 1'b1;
            end
            else
                res_stall <= !no_gaps && $urandom_range(99) < 32;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [7:0][2:0] plan;
        int              roll;
        int              count;
        int              r;
        rst_n = 1'b0;
        req_valid = 1'b0;
        kind = KIND_MARK;
        queen_row = 3'd0;
        queen_col = 3'd0;
        no_gaps = 1'b0;
        squeeze_req = 1'b0;
        requests_sent = 0;
        quiet_cycles = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty board, corners, conflicts, repeated mark
        send_request(KIND_SOLVE, 3'd7, 3'd7);
        mark_request(3'd0, 3'd0);
        send_request(KIND_SOLVE, 3'd0, 3'd0);
        mark_request(3'd7, 3'd7);
        solve_request();
        mark_request(3'd0, 3'd7);
        mark_request(3'd7, 3'd0);
        solve_request();
        mark_request(3'd3, 3'd2);
        mark_request(3'd3, 3'd5);
        solve_request();
        mark_request(3'd2, 3'd2);
        mark_request(3'd5, 3'd5);
        solve_request();
        mark_request(3'd1, 3'd6);
        mark_request(3'd4, 3'd6);
        solve_request();
        mark_request(3'd4, 3'd4);
        mark_request(3'd4, 3'd4);
        solve_request();

        while (requests_sent < ITEM_TARGET)
        begin
            no_gaps = requests_sent >= 120 && requests_sent < 170;
            if (requests_sent >= 200)
                squeeze_req = 1'b1;
            roll = $urandom_range(99);
            if (roll < 70)
            begin
                pick_placement(plan);
                if (roll < 10)
                begin
                    for (r = 0; r < BOARD; r++)
                        mark_request(3'(r), plan[r]);
                end
                else
                begin
                    count = $urandom_range(1, 5);
                    repeat (count)
                    begin
                        r = $urandom_range(7);
                        mark_request(3'(r), plan[r]);
                    end
                end
                // broken sequence: a stray mark that usually conflicts
                if (roll >= 55)
                    mark_request(3'($urandom_range(7)), 3'($urandom_range(7)));
            end
            else
            begin
                count = $urandom_range(0, 3);
                repeat (count)
                    mark_request(3'($urandom_range(7)), 3'($urandom_range(7)));
            end
            solve_request();
        end
        no_gaps = 1'b0;

        @(negedge clk);
        req_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
